FILE: rtl/cbz_pkg.sv
package cbz_pkg;

	localparam int COORD_BITS  = 16;
	localparam int T_FRAC_BITS = 16;
	localparam int T_BITS      = T_FRAC_BITS + 1;
	localparam int DIFF_BITS   = COORD_BITS + 1;
	localparam int PROD_BITS   = DIFF_BITS + T_BITS + 1;
	localparam int SUM_BITS    = PROD_BITS - T_FRAC_BITS + 1;
	localparam int CFG_IDX_BITS = 3;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [T_BITS-1:0]            t_t;
	typedef logic [CFG_IDX_BITS-1:0]      cfg_idx_t;

	localparam t_t T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_START_X  = 3'd0,
		REG_START_Y  = 3'd1,
		REG_CTRL_A_X = 3'd2,
		REG_CTRL_A_Y = 3'd3,
		REG_CTRL_B_X = 3'd4,
		REG_CTRL_B_Y = 3'd5,
		REG_END_X    = 3'd6,
		REG_END_Y    = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		coord_t ab_x;
		coord_t ab_y;
		coord_t bc_x;
		coord_t bc_y;
		coord_t cd_x;
		coord_t cd_y;
	} lvl1_t;

	typedef struct packed {
		coord_t first_x;
		coord_t first_y;
		coord_t second_x;
		coord_t second_y;
	} lvl2_t;

endpackage

FILE: rtl/cubic_bezier_point_eval_unit.sv
// three 3-stage lerp levels lie between request accept and out_valid
// throughput: one request per cycle; the whole pipe holds while the output is stalled
// each lerp level: subtract stage, 17x18 multiply stage, round-toward-zero stage
// reset: arst_n clears all valid bits and the control point registers to zero
module cubic_bezier_point_eval_unit
	import cbz_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  cfg_idx_t cfg_index,
	input  coord_t   cfg_data,
	input  logic     in_valid,
	output logic     in_stall,
	input  t_t       param_t,
	output logic     out_valid,
	input  logic     out_stall,
	output coord_t   lvl1_ab_x,
	output coord_t   lvl1_ab_y,
	output coord_t   lvl1_bc_x,
	output coord_t   lvl1_bc_y,
	output coord_t   lvl1_cd_x,
	output coord_t   lvl1_cd_y,
	output coord_t   lvl2_first_x,
	output coord_t   lvl2_first_y,
	output coord_t   lvl2_second_x,
	output coord_t   lvl2_second_y,
	output coord_t   curve_x,
	output coord_t   curve_y
);

	coord_t start_x_q, start_y_q, ctrl_a_x_q, ctrl_a_y_q;
	coord_t ctrl_b_x_q, ctrl_b_y_q, end_x_q, end_y_q;

	logic [8:0] vld_s;
	logic       en;
	t_t         t_in;
	t_t         t_s1, t_s2, t_s3, t_s4, t_s5, t_s6;
	lvl1_t      lvl1_s3, lvl1_s4, lvl1_s5, lvl1_s6, lvl1_s7, lvl1_s8, lvl1_s9;
	lvl2_t      lvl2_s6, lvl2_s7, lvl2_s8, lvl2_s9;
	coord_t     cx_s9, cy_s9;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q  <= '0;
			start_y_q  <= '0;
			ctrl_a_x_q <= '0;
			ctrl_a_y_q <= '0;
			ctrl_b_x_q <= '0;
			ctrl_b_y_q <= '0;
			end_x_q    <= '0;
			end_y_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_START_X:  start_x_q  <= cfg_data;
				REG_START_Y:  start_y_q  <= cfg_data;
				REG_CTRL_A_X: ctrl_a_x_q <= cfg_data;
				REG_CTRL_A_Y: ctrl_a_y_q <= cfg_data;
				REG_CTRL_B_X: ctrl_b_x_q <= cfg_data;
				REG_CTRL_B_Y: ctrl_b_y_q <= cfg_data;
				REG_END_X:    end_x_q    <= cfg_data;
				REG_END_Y:    end_y_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// one shared enable: the pipe only freezes when a finished request is held
	assign en       = !(vld_s[8] && out_stall);
	assign in_stall = !en;

	// t above one saturates to one
	assign t_in = (param_t[T_BITS-1] && (|param_t[T_FRAC_BITS-1:0])) ? T_ONE : param_t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[7:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1    <= t_in;
			t_s2    <= t_s1;
			t_s3    <= t_s2;
			t_s4    <= t_s3;
			t_s5    <= t_s4;
			t_s6    <= t_s5;
			lvl1_s4 <= lvl1_s3;
			lvl1_s5 <= lvl1_s4;
			lvl1_s6 <= lvl1_s5;
			lvl1_s7 <= lvl1_s6;
			lvl1_s8 <= lvl1_s7;
			lvl1_s9 <= lvl1_s8;
			lvl2_s7 <= lvl2_s6;
			lvl2_s8 <= lvl2_s7;
			lvl2_s9 <= lvl2_s8;
		end
	end

	// first level
	cbz_lerp u_ab_x (.clk(clk), .en(en), .t(t_in), .a(start_x_q), .b(ctrl_a_x_q),
		.q(lvl1_s3.ab_x));
	cbz_lerp u_ab_y (.clk(clk), .en(en), .t(t_in), .a(start_y_q), .b(ctrl_a_y_q),
		.q(lvl1_s3.ab_y));
	cbz_lerp u_bc_x (.clk(clk), .en(en), .t(t_in), .a(ctrl_a_x_q), .b(ctrl_b_x_q),
		.q(lvl1_s3.bc_x));
	cbz_lerp u_bc_y (.clk(clk), .en(en), .t(t_in), .a(ctrl_a_y_q), .b(ctrl_b_y_q),
		.q(lvl1_s3.bc_y));
	cbz_lerp u_cd_x (.clk(clk), .en(en), .t(t_in), .a(ctrl_b_x_q), .b(end_x_q),
		.q(lvl1_s3.cd_x));
	cbz_lerp u_cd_y (.clk(clk), .en(en), .t(t_in), .a(ctrl_b_y_q), .b(end_y_q),
		.q(lvl1_s3.cd_y));

	// second level
	cbz_lerp u_f1_x (.clk(clk), .en(en), .t(t_s3), .a(lvl1_s3.ab_x), .b(lvl1_s3.bc_x),
		.q(lvl2_s6.first_x));
	cbz_lerp u_f1_y (.clk(clk), .en(en), .t(t_s3), .a(lvl1_s3.ab_y), .b(lvl1_s3.bc_y),
		.q(lvl2_s6.first_y));
	cbz_lerp u_f2_x (.clk(clk), .en(en), .t(t_s3), .a(lvl1_s3.bc_x), .b(lvl1_s3.cd_x),
		.q(lvl2_s6.second_x));
	cbz_lerp u_f2_y (.clk(clk), .en(en), .t(t_s3), .a(lvl1_s3.bc_y), .b(lvl1_s3.cd_y),
		.q(lvl2_s6.second_y));

	// curve point
	cbz_lerp u_c_x (.clk(clk), .en(en), .t(t_s6), .a(lvl2_s6.first_x),
		.b(lvl2_s6.second_x), .q(cx_s9));
	cbz_lerp u_c_y (.clk(clk), .en(en), .t(t_s6), .a(lvl2_s6.first_y),
		.b(lvl2_s6.second_y), .q(cy_s9));

	assign out_valid     = vld_s[8];
	assign lvl1_ab_x     = lvl1_s9.ab_x;
	assign lvl1_ab_y     = lvl1_s9.ab_y;
	assign lvl1_bc_x     = lvl1_s9.bc_x;
	assign lvl1_bc_y     = lvl1_s9.bc_y;
	assign lvl1_cd_x     = lvl1_s9.cd_x;
	assign lvl1_cd_y     = lvl1_s9.cd_y;
	assign lvl2_first_x  = lvl2_s9.first_x;
	assign lvl2_first_y  = lvl2_s9.first_y;
	assign lvl2_second_x = lvl2_s9.second_x;
	assign lvl2_second_y = lvl2_s9.second_y;
	assign curve_x       = cx_s9;
	assign curve_y       = cy_s9;

	// an interpolated point always lies between its two operands
	a_curve_x_between: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((curve_x >= lvl2_first_x && curve_x <= lvl2_second_x) ||
			(curve_x <= lvl2_first_x && curve_x >= lvl2_second_x)))
		else $error("curve_x outside second-level span");

	a_curve_y_between: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((curve_y >= lvl2_first_y && curve_y <= lvl2_second_y) ||
			(curve_y <= lvl2_first_y && curve_y >= lvl2_second_y)))
		else $error("curve_y outside second-level span");

	a_lvl2_between: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((lvl2_first_x >= lvl1_ab_x && lvl2_first_x <= lvl1_bc_x) ||
			(lvl2_first_x <= lvl1_ab_x && lvl2_first_x >= lvl1_bc_x)))
		else $error("lvl2_first_x outside first-level span");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(vld_s)))
		else $error("pipeline advanced while output stalled");

endmodule

FILE: rtl/cbz_lerp.sv
module cbz_lerp
	import cbz_pkg::*;
(
	input  logic   clk,
	input  logic   en,
	input  t_t     t,
	input  coord_t a,
	input  coord_t b,
	output coord_t q
);

	logic signed [DIFF_BITS-1:0] diff_s1;
	coord_t                      a_s1;
	t_t                          t_s1;
	logic signed [PROD_BITS-1:0] prod_s2;
	coord_t                      a_s2;
	coord_t                      q_s3;

	logic signed [DIFF_BITS-1:0]          diff;
	logic signed [T_BITS:0]               t_sgn;
	logic signed [SUM_BITS-1:0]           sum;
	logic signed [SUM_BITS-1:0]           rnd;
	logic                                 low_nz;

	assign diff  = {b[COORD_BITS-1], b} - {a[COORD_BITS-1], a};
	assign t_sgn = {1'b0, t_s1};

	// floor(num / one) = a + (prod >>> frac); bump by one for negative inexact
	assign sum = {{(SUM_BITS-COORD_BITS){a_s2[COORD_BITS-1]}}, a_s2}
		+ {prod_s2[PROD_BITS-1], prod_s2[PROD_BITS-1:T_FRAC_BITS]};
	assign low_nz = |prod_s2[T_FRAC_BITS-1:0];
	assign rnd = sum + {{(SUM_BITS-1){1'b0}}, sum[SUM_BITS-1] & low_nz};

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1 <= diff;
			a_s1    <= a;
			t_s1    <= t;
			prod_s2 <= t_sgn * diff_s1;
			a_s2    <= a_s1;
			q_s3    <= rnd[COORD_BITS-1:0];
		end
	end

	assign q = q_s3;

endmodule
